### rtl/core/flat_field_correction_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the flat-field correction block.
// Both expect clk and arst_n in the scope of use.
// ---------------------------------------------------------------------------
`ifndef FLAT_FIELD_CORRECTION_TOP_MACROS_SVH
`define FLAT_FIELD_CORRECTION_TOP_MACROS_SVH

// same-cycle implication
`define FFC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ffc: property violated");

// next-cycle implication
`define FFC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffc: property violated");

`endif

### rtl/core/ffc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffc_pkg
// Widths, beat types and controller codes for the flat-field correction.
// ---------------------------------------------------------------------------
package ffc_pkg;

	localparam int PIXEL_BITS = 16;
	localparam int MAX_PIXELS = 1048576;
	localparam int PORT_PIX_W = 16;
	localparam int OUT_W      = 32;
	localparam int FRAC_BITS  = 8;

	localparam int PIX_W   = PIXEL_BITS;
	localparam int CNT_W   = $clog2(MAX_PIXELS + 1);
	localparam int TOT_W   = PIX_W + $clog2(MAX_PIXELS);
	localparam int AVG_W   = PIX_W + FRAC_BITS;
	localparam int MAG_W   = PIX_W + AVG_W;
	localparam int PROD_W  = MAG_W + 2;
	localparam int SUM_W   = (MAG_W + 2 > OUT_W + 1) ? MAG_W + 2 : OUT_W + 1;
	localparam int DVD_RAW = (TOT_W + FRAC_BITS > MAG_W) ? TOT_W + FRAC_BITS : MAG_W;

	localparam int DIV_RADIX = 4;
	localparam int DIV_STEPS = (DVD_RAW + DIV_RADIX - 1) / DIV_RADIX;
	localparam int DVD_W     = DIV_STEPS * DIV_RADIX;
	localparam int DVS_W     = (CNT_W > PIX_W) ? CNT_W : PIX_W;
	localparam int STEP_CW   = $clog2(DIV_STEPS + 1);

	typedef struct packed {
		logic                  op;
		logic                  first;
		logic [PORT_PIX_W-1:0] raw_pixel;
		logic [PORT_PIX_W-1:0] flat_pixel;
		logic [PORT_PIX_W-1:0] dark_pixel;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] corrected;
		logic                    low_contrast;
		logic                    no_reference;
		logic                    saturated;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FLAT_GO,
		ST_FLAT_WAIT,
		ST_DARK_GO,
		ST_DARK_WAIT,
		ST_MUL,
		ST_CORR_GO,
		ST_CORR_WAIT,
		ST_SUM,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		DIV_FLAT,
		DIV_DARK,
		DIV_CORR
	} div_sel_t;

	typedef struct packed {
		logic     acc;
		logic     latch;
		logic     div_start;
		div_sel_t div_sel;
		logic     store_flat;
		logic     store_dark;
		logic     do_mul;
		logic     store_quo;
		logic     do_sum;
		logic     load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic avg_ready;
		logic low_contrast;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

### rtl/core/ffc_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffc_in_if / ffc_out_if
// Valid/ready stream channels for pixel triples and corrected pixels.
// ---------------------------------------------------------------------------
interface ffc_in_if ();
	logic             valid;
	logic             ready;
	ffc_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ffc_out_if ();
	logic              valid;
	logic              ready;
	ffc_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/ffc_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffc_div
// Unsigned restoring divider, DIV_RADIX quotient bits per cycle.
// ---------------------------------------------------------------------------
module ffc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ffc_pkg::DVD_W-1:0]  dividend,
	input  logic [ffc_pkg::DVS_W-1:0]  divisor,
	output logic                       busy,
	output logic                       done,
	output logic [ffc_pkg::DVD_W-1:0]  quotient
);

	logic [ffc_pkg::DVS_W-1:0]   rem_q, rem_d;
	logic [ffc_pkg::DVD_W-1:0]   quo_q, quo_d;
	logic [ffc_pkg::DVS_W-1:0]   dvs_q;
	logic [ffc_pkg::STEP_CW-1:0] cnt_q;
	logic                        busy_q, done_q;

	always_comb begin
		logic [ffc_pkg::DVS_W-1:0] r;
		logic [ffc_pkg::DVD_W-1:0] q;
		logic [ffc_pkg::DVS_W:0]   t;
		r = rem_q;
		q = quo_q;
		t = '0;
		for (int i = 0; i < ffc_pkg::DIV_RADIX; i++) begin
			t = {r, q[ffc_pkg::DVD_W-1]};
			q = {q[ffc_pkg::DVD_W-2:0], 1'b0};
			if (t >= {1'b0, dvs_q}) begin
				t    = t - {1'b0, dvs_q};
				q[0] = 1'b1;
			end
			r = t[ffc_pkg::DVS_W-1:0];
		end
		rem_d = r;
		quo_d = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ffc_pkg::STEP_CW'(ffc_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ffc_pkg::STEP_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/core/ffc_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffc_ctrl
// Sequencer: accumulate beats, averaging, multiply, divide, result hand-off.
// ---------------------------------------------------------------------------
module ffc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_op,
	input  ffc_pkg::dp_status_t status,
	output logic                in_ready,
	output ffc_pkg::ctrl_cmd_t  cmd
);

	ffc_pkg::state_t st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ffc_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ffc_pkg::ST_IDLE: begin
				if (in_valid && in_op) begin
					if (!status.avg_ready && !status.count_zero) begin
						st_d = ffc_pkg::ST_FLAT_GO;
					end else begin
						st_d = ffc_pkg::ST_MUL;
					end
				end
			end
			ffc_pkg::ST_FLAT_GO: st_d = ffc_pkg::ST_FLAT_WAIT;
			ffc_pkg::ST_FLAT_WAIT: begin
				if (status.div_done) begin
					st_d = ffc_pkg::ST_DARK_GO;
				end
			end
			ffc_pkg::ST_DARK_GO: st_d = ffc_pkg::ST_DARK_WAIT;
			ffc_pkg::ST_DARK_WAIT: begin
				if (status.div_done) begin
					st_d = ffc_pkg::ST_MUL;
				end
			end
			ffc_pkg::ST_MUL: begin
				if (status.count_zero || status.low_contrast) begin
					st_d = ffc_pkg::ST_SUM;
				end else begin
					st_d = ffc_pkg::ST_CORR_GO;
				end
			end
			ffc_pkg::ST_CORR_GO: st_d = ffc_pkg::ST_CORR_WAIT;
			ffc_pkg::ST_CORR_WAIT: begin
				if (status.div_done) begin
					st_d = ffc_pkg::ST_SUM;
				end
			end
			ffc_pkg::ST_SUM: st_d = ffc_pkg::ST_EMIT;
			ffc_pkg::ST_EMIT: begin
				if (status.out_free) begin
					st_d = ffc_pkg::ST_IDLE;
				end
			end
			default: st_d = ffc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		cmd.div_sel = ffc_pkg::DIV_CORR;
		unique case (st_q)
			ffc_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.acc   = in_valid && !in_op;
				cmd.latch = in_valid && in_op;
			end
			ffc_pkg::ST_FLAT_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = ffc_pkg::DIV_FLAT;
			end
			ffc_pkg::ST_FLAT_WAIT: cmd.store_flat = status.div_done;
			ffc_pkg::ST_DARK_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = ffc_pkg::DIV_DARK;
			end
			ffc_pkg::ST_DARK_WAIT: cmd.store_dark = status.div_done;
			ffc_pkg::ST_MUL:       cmd.do_mul     = 1'b1;
			ffc_pkg::ST_CORR_GO:   cmd.div_start  = 1'b1;
			ffc_pkg::ST_CORR_WAIT: cmd.store_quo  = status.div_done;
			ffc_pkg::ST_SUM:       cmd.do_sum     = 1'b1;
			ffc_pkg::ST_EMIT:      cmd.load_out   = status.out_free;
			default: ;
		endcase
	end

endmodule

### rtl/core/ffc_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffc_dp
// Reference totals, averages, gain multiply, shared divider, output register.
// ---------------------------------------------------------------------------
`include "flat_field_correction_top_macros.svh"

module ffc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  ffc_pkg::in_item_t   item,
	input  ffc_pkg::ctrl_cmd_t  cmd,
	output ffc_pkg::dp_status_t status,
	input  logic                out_ready,
	output logic                out_valid,
	output ffc_pkg::out_item_t  out_data
);

	localparam logic signed [ffc_pkg::SUM_W-1:0] SAT_HI =
		{{(ffc_pkg::SUM_W - ffc_pkg::OUT_W + 1){1'b0}}, {(ffc_pkg::OUT_W - 1){1'b1}}};
	localparam logic signed [ffc_pkg::SUM_W-1:0] SAT_LO = ~SAT_HI;

	logic [ffc_pkg::TOT_W-1:0] flat_tot_q, dark_tot_q;
	logic [ffc_pkg::CNT_W-1:0] cnt_q;
	logic [ffc_pkg::AVG_W-1:0] flat_avg_q, dark_avg_q;
	logic                      avg_ready_q;
	logic                      out_valid_q;

	logic [ffc_pkg::PIX_W-1:0] raw_q, flat_q, dark_q;
	logic signed [ffc_pkg::PROD_W-1:0] prod_s2;
	logic signed [ffc_pkg::SUM_W-1:0]  quo_s3;
	ffc_pkg::out_item_t res_q, out_q;

	logic [ffc_pkg::TOT_W-1:0] base_flat, base_dark;
	logic [ffc_pkg::CNT_W-1:0] base_cnt;
	logic [ffc_pkg::PIX_W-1:0] in_flat, in_dark;
	logic                      count_zero, low_contrast;

	logic signed [ffc_pkg::PIX_W:0]    diff;
	logic signed [ffc_pkg::AVG_W:0]    gain;
	logic signed [ffc_pkg::PROD_W-1:0] prod_c;
	logic [ffc_pkg::PROD_W-1:0]        prod_abs;
	logic [ffc_pkg::PIX_W-1:0]         contrast;
	logic [ffc_pkg::SUM_W-1:0]         qmag;
	logic signed [ffc_pkg::SUM_W-1:0]  val;
	ffc_pkg::out_item_t                res_d;

	logic [ffc_pkg::DVD_W-1:0] dvd;
	logic [ffc_pkg::DVS_W-1:0] dvs;
	logic                      div_busy, div_done;
	logic [ffc_pkg::DVD_W-1:0] div_quo;

	assign in_flat      = item.flat_pixel[ffc_pkg::PIX_W-1:0];
	assign in_dark      = item.dark_pixel[ffc_pkg::PIX_W-1:0];
	assign count_zero   = (cnt_q == '0);
	assign low_contrast = (flat_q <= dark_q);

	always_comb begin
		base_flat = item.first ? '0 : flat_tot_q;
		base_dark = item.first ? '0 : dark_tot_q;
		base_cnt  = item.first ? '0 : cnt_q;
	end

	// reference totals and averages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flat_tot_q  <= '0;
			dark_tot_q  <= '0;
			cnt_q       <= '0;
			flat_avg_q  <= '0;
			dark_avg_q  <= '0;
			avg_ready_q <= 1'b0;
		end else begin
			if (cmd.acc) begin
				avg_ready_q <= 1'b0;
				if (base_cnt < ffc_pkg::CNT_W'(ffc_pkg::MAX_PIXELS)) begin
					flat_tot_q <= base_flat + ffc_pkg::TOT_W'(in_flat);
					dark_tot_q <= base_dark + ffc_pkg::TOT_W'(in_dark);
					cnt_q      <= base_cnt + 1'b1;
				end else begin
					flat_tot_q <= base_flat;
					dark_tot_q <= base_dark;
					cnt_q      <= base_cnt;
				end
			end
			if (cmd.latch && !avg_ready_q && count_zero) begin
				flat_avg_q  <= '0;
				dark_avg_q  <= '0;
				avg_ready_q <= 1'b1;
			end
			if (cmd.store_flat) begin
				flat_avg_q <= div_quo[ffc_pkg::AVG_W-1:0];
			end
			if (cmd.store_dark) begin
				dark_avg_q  <= div_quo[ffc_pkg::AVG_W-1:0];
				avg_ready_q <= 1'b1;
			end
		end
	end

	// gain term and divider operands
	assign diff     = $signed({1'b0, raw_q}) - $signed({1'b0, dark_q});
	assign gain     = $signed({1'b0, flat_avg_q}) - $signed({1'b0, dark_avg_q});
	assign prod_c   = diff * gain;
	assign prod_abs = prod_s2[ffc_pkg::PROD_W-1] ? ffc_pkg::PROD_W'(-prod_s2)
		: ffc_pkg::PROD_W'(prod_s2);
	assign contrast = flat_q - dark_q;

	always_comb begin
		unique case (cmd.div_sel)
			ffc_pkg::DIV_FLAT: begin
				dvd = ffc_pkg::DVD_W'({flat_tot_q, {ffc_pkg::FRAC_BITS{1'b0}}});
				dvs = ffc_pkg::DVS_W'(cnt_q);
			end
			ffc_pkg::DIV_DARK: begin
				dvd = ffc_pkg::DVD_W'({dark_tot_q, {ffc_pkg::FRAC_BITS{1'b0}}});
				dvs = ffc_pkg::DVS_W'(cnt_q);
			end
			ffc_pkg::DIV_CORR: begin
				dvd = ffc_pkg::DVD_W'(prod_abs[ffc_pkg::MAG_W-1:0]);
				dvs = ffc_pkg::DVS_W'(contrast);
			end
			default: begin
				dvd = '0;
				dvs = '0;
			end
		endcase
	end

	ffc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// offset, saturation and flags
	assign qmag = ffc_pkg::SUM_W'(div_quo[ffc_pkg::MAG_W-1:0]);
	assign val  = quo_s3 + $signed(ffc_pkg::SUM_W'(dark_avg_q));

	always_comb begin
		res_d = '0;
		priority if (count_zero) begin
			res_d.no_reference = 1'b1;
		end else if (low_contrast) begin
			res_d.low_contrast = 1'b1;
			res_d.corrected    = ffc_pkg::OUT_W'(dark_avg_q);
		end else if (val > SAT_HI) begin
			res_d.corrected = SAT_HI[ffc_pkg::OUT_W-1:0];
			res_d.saturated = 1'b1;
		end else if (val < SAT_LO) begin
			res_d.corrected = SAT_LO[ffc_pkg::OUT_W-1:0];
			res_d.saturated = 1'b1;
		end else begin
			res_d.corrected = val[ffc_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			raw_q  <= item.raw_pixel[ffc_pkg::PIX_W-1:0];
			flat_q <= in_flat;
			dark_q <= in_dark;
		end
		if (cmd.do_mul) begin
			prod_s2 <= prod_c;
		end
		if (cmd.store_quo) begin
			quo_s3 <= prod_s2[ffc_pkg::PROD_W-1] ? -$signed(qmag) : $signed(qmag);
		end
		if (cmd.do_sum) begin
			res_q <= res_d;
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign status.count_zero   = count_zero;
	assign status.avg_ready    = avg_ready_q;
	assign status.low_contrast = low_contrast;
	assign status.div_done     = div_done;
	assign status.out_free     = !out_valid_q || out_ready;

	`FFC_ASSERT_IMP(a_div_start_idle, cmd.div_start, !div_busy)
	`FFC_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid_q || out_ready)
	`FFC_ASSERT_NEXT(a_acc_drops_avg, cmd.acc, !avg_ready_q)
	`FFC_ASSERT_IMP(a_flags_exclusive, out_valid_q,
		!(out_q.low_contrast && out_q.no_reference))
	`FFC_ASSERT_IMP(a_sat_normal_only, out_valid_q && out_q.saturated,
		!out_q.low_contrast && !out_q.no_reference)

endmodule

### rtl/core/flat_field_correction_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flat_field_correction_top
// Dark and gain flat-field correction of streamed pixel triples.
// ---------------------------------------------------------------------------
//  channel  dir  payload                                        beat
//  pixel    in   op, first, raw/flat/dark pixel                 each triple
//  result   out  corrected Q23.8, low_contrast, no_reference,   op 1 only
//                saturated
//
//  Accumulate beats are taken back to back, one per cycle, while the sequencer is idle.
//  A correct beat runs a division on the shared divider at 4 quotient
//  bits a cycle; the first after an accumulate pass adds two average
//  divisions. Low-contrast and empty-reference beats skip the correction
//  division. The result register frees pixel while a result waits;
//  a stalled result holds the sequencer in its last step.
//  Reset clears totals, count, averages and valid state.
// ---------------------------------------------------------------------------
module flat_field_correction_top (
	input  logic             clk,
	input  logic             arst_n,
	ffc_in_if.sink           pixel,
	ffc_out_if.source        result
);

	ffc_pkg::ctrl_cmd_t  cmd;
	ffc_pkg::dp_status_t status;
	logic                in_ready;

	ffc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixel.valid),
		.in_op    (pixel.data.op),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	ffc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (pixel.data),
		.cmd       (cmd),
		.status    (status),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.out_data  (result.data)
	);

	assign pixel.ready = in_ready;

endmodule

### test/flat_field_correction_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flat_field_correction_top_tb
// Drives pixel triples into the flat-field correction block: a short table
// of hand-picked beats, then random accumulate/correct frames with noise
// mixed in. A model of the dark/gain arithmetic predicts each corrected
// pixel unless a table row gives it literally, and each result beat is
// checked field by field, in order, against the oldest expectation.
// ---------------------------------------------------------------------------
module flat_field_correction_top_tb;

	localparam int     HALF_PERIOD = 10;
	localparam longint RUN_LIMIT_NS = 20_000_000;
	localparam int     RAND_ITEMS = 1500;
	localparam int     LONG_HOLD = 400;
	localparam int     DRAIN_CYCLES = 64;
	localparam int     DIR_ROWS = 21;

	localparam logic OP_ACCUM   = 1'b0;
	localparam logic OP_CORRECT = 1'b1;

	localparam int SAT_HI = 32'sh7FFF_FFFF;
	localparam int SAT_LO = 32'sh8000_0000;

	typedef struct {
		ffc_pkg::in_item_t  item;
		bit                 fixed;
		ffc_pkg::out_item_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ffc_in_if  pixel_bus ();
	ffc_out_if result_bus ();

	flat_field_correction_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel_bus),
		.result (result_bus)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// reference sums and averages
	logic [35:0] flat_sum = '0;
	logic [35:0] dark_sum = '0;
	logic [20:0] n_pixels = '0;
	logic [23:0] flat_avg = '0;
	logic [23:0] dark_avg = '0;
	bit          avg_valid = 1'b0;

	ffc_pkg::out_item_t corr_q[$];
	int                 errors = 0;

	// per-beat literal expectation, travels with the beat
	bit                 lit_on;
	ffc_pkg::out_item_t lit_res;

	int burst_left = 0;
	bit hold_off_req = 1'b0;

	function automatic void correct_pixel(input ffc_pkg::in_item_t it, output bit emits,
			output ffc_pkg::out_item_t res);
		longint diff, gain, span, val;
		res = '0;
		emits = 1'b0;
		if (it.op == OP_ACCUM) begin
			if (it.first) begin
				flat_sum = '0;
				dark_sum = '0;
				n_pixels = '0;
			end
			if (n_pixels < ffc_pkg::MAX_PIXELS) begin
				flat_sum += it.flat_pixel;
				dark_sum += it.dark_pixel;
				n_pixels++;
			end
			avg_valid = 1'b0;
			return;
		end
		emits = 1'b1;
		if (!avg_valid) begin
			if (n_pixels != 0) begin
				flat_avg = 24'((64'(flat_sum) << 8) / 64'(n_pixels));
				dark_avg = 24'((64'(dark_sum) << 8) / 64'(n_pixels));
			end else begin
				flat_avg = '0;
				dark_avg = '0;
			end
			avg_valid = 1'b1;
		end
		if (n_pixels == 0) begin
			res.no_reference = 1'b1;
		end else if (it.flat_pixel <= it.dark_pixel) begin
			res.low_contrast = 1'b1;
			res.corrected = 32'(dark_avg);
		end else begin
			diff = longint'(it.raw_pixel) - longint'(it.dark_pixel);
			gain = longint'(flat_avg) - longint'(dark_avg);
			span = longint'(it.flat_pixel) - longint'(it.dark_pixel);
			val = (diff * gain) / span + longint'(dark_avg);
			if (val > longint'(SAT_HI)) begin
				val = SAT_HI;
				res.saturated = 1'b1;
			end else if (val < longint'(SAT_LO)) begin
				val = SAT_LO;
				res.saturated = 1'b1;
			end
			res.corrected = 32'(val);
		end
	endfunction

	task automatic check_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : scoreboard
		ffc_pkg::out_item_t want, got, pred;
		bit                 emits;
		if (result_bus.valid && result_bus.ready) begin
			got = result_bus.data;
			if (corr_q.size() == 0) begin
				$error("unexpected result beat: corrected %0d", got.corrected);
				errors++;
			end else begin
				want = corr_q.pop_front();
				check_field("corrected", want.corrected, got.corrected);
				check_field("low_contrast", want.low_contrast, got.low_contrast);
				check_field("no_reference", want.no_reference, got.no_reference);
				check_field("saturated", want.saturated, got.saturated);
			end
		end
		if (pixel_bus.valid && pixel_bus.ready) begin
			correct_pixel(pixel_bus.data, emits, pred);
			if (emits)
				corr_q.push_back(lit_on ? lit_res : pred);
		end
	end

	// result side: changing stall patterns, plus a long hold-off on each request
	initial begin : result_sink
		int mode, left, phase;
		result_bus.ready = 1'b0;
		mode = 0;
		left = 0;
		phase = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				result_bus.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(16, 128);
			end
			left--;
			phase++;
			case (mode)
				0: result_bus.ready <= 1'b1;
				1: result_bus.ready <= 1'($urandom_range(0, 1));
				2: result_bus.ready <= (phase % 5 == 0);
				default: result_bus.ready <= ($urandom_range(0, 15) != 0);
			endcase
		end
	end

	task automatic send_pixel(input ffc_pkg::in_item_t it, input bit fixed = 1'b0,
			input ffc_pkg::out_item_t want = '0);
		pixel_bus.data <= it;
		pixel_bus.valid <= 1'b1;
		lit_on <= fixed;
		lit_res <= want;
		do @(posedge clk); while (!pixel_bus.ready);
		if (burst_left == 0) begin
			pixel_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(0, 40);
		end else begin
			burst_left--;
		end
	endtask

	function automatic dir_row_t dir_row(input logic op, input logic first, input int raw,
			input int flat, input int dark, input bit fixed = 1'b0, input int corr = 0,
			input bit lc = 1'b0, input bit nr = 1'b0, input bit sat = 1'b0);
		dir_row_t r;
		r.item.op = op;
		r.item.first = first;
		r.item.raw_pixel = 16'(raw);
		r.item.flat_pixel = 16'(flat);
		r.item.dark_pixel = 16'(dark);
		r.fixed = fixed;
		r.want.corrected = corr;
		r.want.low_contrast = lc;
		r.want.no_reference = nr;
		r.want.saturated = sat;
		return r;
	endfunction

	function automatic logic [15:0] rand_pix();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic ffc_pkg::in_item_t rand_ref(input int style, input bit first);
		ffc_pkg::in_item_t it;
		it.op = OP_ACCUM;
		it.first = first;
		it.raw_pixel = rand_pix();
		case (style)
			1: begin
				it.flat_pixel = 16'($urandom_range(40000, 65535));
				it.dark_pixel = 16'($urandom_range(0, 2000));
			end
			2: begin
				it.flat_pixel = 16'($urandom_range(0, 2000));
				it.dark_pixel = 16'($urandom_range(40000, 65535));
			end
			default: begin
				it.flat_pixel = rand_pix();
				it.dark_pixel = rand_pix();
			end
		endcase
		return it;
	endfunction

	function automatic ffc_pkg::in_item_t rand_correct();
		ffc_pkg::in_item_t it;
		logic [16:0]       top;
		it.op = OP_CORRECT;
		it.first = 1'($urandom);
		it.raw_pixel = rand_pix();
		it.dark_pixel = rand_pix();
		case ($urandom_range(0, 3))
			0: it.flat_pixel = rand_pix();
			1: begin
				top = 17'(it.dark_pixel) + 17'($urandom_range(1, 16));
				it.flat_pixel = top[16] ? 16'hFFFF : top[15:0];
			end
			2: it.flat_pixel = 16'($urandom_range(0, it.dark_pixel));
			default: it.flat_pixel = 16'($urandom_range(it.dark_pixel, 65535));
		endcase
		return it;
	endfunction

	initial begin : stimulus
		dir_row_t          dir_tab [DIR_ROWS];
		ffc_pkg::in_item_t it;
		int                rand_sent, n, m, style;
		bit                cont, hold_due, second_hold;
		pixel_bus.valid = 1'b0;
		pixel_bus.data = '0;
		lit_on = 1'b0;
		lit_res = '0;
		dir_tab = '{
			dir_row(OP_CORRECT, 0, 1234, 2000, 100, 1, 0, 0, 1),
			dir_row(OP_CORRECT, 1, 65535, 65535, 0, 1, 0, 0, 1),
			dir_row(OP_ACCUM, 1, 0, 1000, 200),
			dir_row(OP_ACCUM, 0, 65535, 3000, 600),
			dir_row(OP_CORRECT, 0, 500, 100, 100, 1, 102400, 1),
			dir_row(OP_CORRECT, 0, 0, 50, 60, 1, 102400, 1),
			dir_row(OP_CORRECT, 0, 0, 0, 65535, 1, 102400, 1),
			dir_row(OP_CORRECT, 0, 65535, 65535, 0),
			dir_row(OP_CORRECT, 0, 0, 2000, 1000),
			dir_row(OP_CORRECT, 0, 300, 1800, 200),
			dir_row(OP_ACCUM, 1, 0, 65535, 0),
			dir_row(OP_CORRECT, 0, 65535, 1, 0, 1, SAT_HI, 0, 0, 1),
			dir_row(OP_CORRECT, 0, 0, 65535, 65534, 1, SAT_LO, 0, 0, 1),
			dir_row(OP_CORRECT, 0, 65535, 65535, 65534),
			dir_row(OP_ACCUM, 1, 65535, 0, 0),
			dir_row(OP_CORRECT, 0, 65535, 65535, 0),
			dir_row(OP_ACCUM, 0, 12345, 0, 65535),
			dir_row(OP_CORRECT, 0, 65535, 2, 1, 1, SAT_LO, 0, 0, 1),
			dir_row(OP_CORRECT, 1, 0, 65535, 1),
			dir_row(OP_ACCUM, 0, 1, 1, 1),
			dir_row(OP_CORRECT, 0, 40000, 50000, 100)
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_pixel(dir_tab[i].item, dir_tab[i].fixed, dir_tab[i].want);

		rand_sent = 0;
		hold_due = 1'b1;
		second_hold = 1'b0;
		while (rand_sent < RAND_ITEMS) begin
			if ($urandom_range(0, 9) < 8) begin
				style = $urandom_range(0, 2);
				cont = ($urandom_range(0, 5) == 0);
				n = $urandom_range(1, 20);
				for (int i = 0; i < n; i++)
					send_pixel(rand_ref(style, (i == 0) && !cont));
				if (hold_due) begin
					hold_off_req = 1'b1;
					hold_due = 1'b0;
				end
				m = $urandom_range(1, 24);
				for (int i = 0; i < m; i++)
					send_pixel(rand_correct());
				rand_sent += n + m;
			end else begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++) begin
					it.op = 1'($urandom);
					it.first = 1'($urandom);
					it.raw_pixel = rand_pix();
					it.flat_pixel = rand_pix();
					it.dark_pixel = rand_pix();
					send_pixel(it);
				end
				rand_sent += n;
			end
			if (!second_hold && rand_sent > RAND_ITEMS / 2) begin
				second_hold = 1'b1;
				hold_due = 1'b1;
			end
		end
		pixel_bus.valid <= 1'b0;

		@(posedge clk);
		while (corr_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/ffc_pkg.sv
rtl/core/ffc_if.sv
rtl/core/ffc_div.sv
rtl/core/ffc_ctrl.sv
rtl/core/ffc_dp.sv
rtl/core/flat_field_correction_top.sv
test/flat_field_correction_top_tb.sv
